// ----- sv/command_frame_builder_crc16_top_defines.svh -----
// ----------------------------------------------------------------------------
// Command frame builder assertion macros
// Shared concurrent assertion forms for the frame builder blocks.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_BUILDER_CRC16_TOP_DEFINES_SVH
`define COMMAND_FRAME_BUILDER_CRC16_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame builder check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define CFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame builder check failed one cycle later");

`endif

// ----- sv/cfb_pkg.sv -----
// ----------------------------------------------------------------------------
// Command frame builder package
// Types, constants and the CRC-16 byte update shared by the frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

	localparam int BYTE_W        = 8;
	localparam int PARAM2_W      = 16;
	localparam int CRC_W         = 16;

	localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h8005;
	localparam logic [CRC_W-1:0]  CRC_INIT   = 16'h0000;
	localparam logic [BYTE_W-1:0] COUNT_BIAS = 8'd7;
	localparam logic [BYTE_W-1:0] LEN_ONE    = 8'h01;
	localparam logic [BYTE_W-1:0] LEN_ZERO   = 8'h00;

	// Command queue between the front and the back.
	localparam int CMD_FIFO_DEPTH = 4;
	localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
	localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

	// Operation code of an input request.
	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_DATA   = 1'b1;

	typedef enum logic {
		KIND_HEADER,
		KIND_DATA
	} cmd_kind_t;

	// One classified command for the back end.
	typedef struct packed {
		cmd_kind_t           kind;
		logic                last;
		logic [BYTE_W-1:0]   count;
		logic [BYTE_W-1:0]   code;
		logic [BYTE_W-1:0]   param1;
		logic [PARAM2_W-1:0] param2;
		logic [BYTE_W-1:0]   data;
	} cmd_t;

	// Byte sequencer steps of the back end.
	typedef enum logic [2:0] {
		STEP_COUNT,
		STEP_CODE,
		STEP_P1,
		STEP_P2_HI,
		STEP_P2_LO,
		STEP_DATA,
		STEP_CRC_LO,
		STEP_CRC_HI
	} step_t;

	typedef struct packed {
		logic frame_open;
	} front_status_t;

	typedef struct packed {
		logic busy;
	} back_status_t;

	// Feed one byte, least significant bit first, into the left-shifting CRC.
	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
		input logic [BYTE_W-1:0] data_in);
		logic [CRC_W-1:0] crc;
		logic             fb;
		crc = crc_in;
		for (int i = 0; i < BYTE_W; i++) begin
			fb  = data_in[i] ^ crc[CRC_W-1];
			crc = {crc[CRC_W-2:0], 1'b0};
			if (fb) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

endpackage

// ----- sv/cfb_req_if.sv -----
// ----------------------------------------------------------------------------
// Command frame builder request channel
// Valid/ready channel that carries header and data requests.
// ----------------------------------------------------------------------------
interface cfb_req_if
	import cfb_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic                operation;
	logic [BYTE_W-1:0]   command_code;
	logic [BYTE_W-1:0]   first_param;
	logic [PARAM2_W-1:0] second_param;
	logic [BYTE_W-1:0]   payload_length;
	logic [BYTE_W-1:0]   payload_byte;

	modport source (
		output valid, operation, command_code, first_param, second_param,
			payload_length, payload_byte,
		input  ready
	);

	modport sink (
		input  valid, operation, command_code, first_param, second_param,
			payload_length, payload_byte,
		output ready
	);
endinterface

// ----- sv/cfb_frame_if.sv -----
// ----------------------------------------------------------------------------
// Command frame builder frame channel
// Valid/ready channel that carries the outgoing frame bytes.
// ----------------------------------------------------------------------------
interface cfb_frame_if
	import cfb_pkg::*;
	;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic              frame_end;

	modport source (
		output valid, frame_byte, frame_end,
		input  ready
	);

	modport sink (
		input  valid, frame_byte, frame_end,
		output ready
	);
endinterface

// ----- sv/cfb_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// Command frame builder command queue
// Small register queue that decouples the classifier from the sequencer.
// ----------------------------------------------------------------------------
module cfb_cmd_fifo
	import cfb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	cmd_t                 mem_q [CMD_FIFO_DEPTH];
	logic [CMD_PTR_W-1:0] wptr_q;
	logic [CMD_PTR_W-1:0] rptr_q;
	logic [CMD_CNT_W-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != CMD_CNT_W'(CMD_FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = mem_q[rptr_q];

	// Storage is written at the write pointer.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/cfb_front.sv -----
// ----------------------------------------------------------------------------
// Command frame builder front end
// Accepts requests, tracks the open frame and queues classified commands.
// ----------------------------------------------------------------------------
module cfb_front
	import cfb_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	cfb_req_if.sink       req,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output cmd_t          cmd,
	output front_status_t status
);

	logic              frame_open_q;
	logic [BYTE_W-1:0] remaining_q;
	logic              accept;
	logic              is_header;

	assign is_header     = (req.operation == OP_HEADER);
	assign req.ready     = cmd_ready;
	assign accept        = req.valid && req.ready;
	// A data request with no open frame is accepted and dropped.
	assign cmd_valid     = req.valid && (is_header || frame_open_q);
	assign status.frame_open = frame_open_q;

	// Build the command from the request fields.
	always_comb begin
		cmd.kind   = is_header ? KIND_HEADER : KIND_DATA;
		cmd.last   = is_header ? (req.payload_length == LEN_ZERO) : (remaining_q == LEN_ONE);
		cmd.count  = req.payload_length + COUNT_BIAS;
		cmd.code   = req.command_code;
		cmd.param1 = req.first_param;
		cmd.param2 = req.second_param;
		cmd.data   = req.payload_byte;
	end

	// Frame tracking: a header restarts the frame, data counts it down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			remaining_q  <= '0;
		end else if (accept) begin
			if (is_header) begin
				frame_open_q <= (req.payload_length != LEN_ZERO);
				remaining_q  <= req.payload_length;
			end else if (frame_open_q) begin
				remaining_q <= remaining_q - 1'b1;
				if (remaining_q == LEN_ONE) begin
					frame_open_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- sv/cfb_back.sv -----
// ----------------------------------------------------------------------------
// Command frame builder back end
// Sequences command bytes onto the frame channel and appends the CRC.
// ----------------------------------------------------------------------------
module cfb_back
	import cfb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_ready,
	input  cmd_t         cmd,
	cfb_frame_if.source  frame,
	output back_status_t status
);

	cmd_t              cmd_q;
	step_t             step_q;
	step_t             step_nxt;
	logic              busy_q;
	logic [CRC_W-1:0]  crc_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_end_q;
	logic              advance;
	logic              done;
	logic              pop;
	logic [BYTE_W-1:0] byte_d;
	logic              end_d;
	logic              feed_d;
	logic [CRC_W-1:0]  crc_base;

	assign advance     = busy_q && (!out_valid_q || frame.ready);
	assign pop         = cmd_valid && (!busy_q || (advance && done));
	assign cmd_ready   = !busy_q || (advance && done);
	assign frame.valid      = out_valid_q;
	assign frame.frame_byte = out_byte_q;
	assign frame.frame_end  = out_end_q;
	assign status.busy = busy_q;

	// Next step of the byte sequencer.
	always_comb begin
		step_nxt = step_q;
		done     = 1'b0;
		case (step_q)
			STEP_COUNT:  step_nxt = STEP_CODE;
			STEP_CODE:   step_nxt = STEP_P1;
			STEP_P1:     step_nxt = STEP_P2_HI;
			STEP_P2_HI:  step_nxt = STEP_P2_LO;
			STEP_P2_LO, STEP_DATA: begin
				if (cmd_q.last) begin
					step_nxt = STEP_CRC_LO;
				end else begin
					done = 1'b1;
				end
			end
			STEP_CRC_LO: step_nxt = STEP_CRC_HI;
			STEP_CRC_HI: done = 1'b1;
			default:     done = 1'b1;
		endcase
	end

	// Byte, end flag and CRC feed for the current step.
	always_comb begin
		byte_d   = '0;
		end_d    = 1'b0;
		feed_d   = 1'b1;
		crc_base = crc_q;
		case (step_q)
			STEP_COUNT: begin
				byte_d   = cmd_q.count;
				crc_base = CRC_INIT;
			end
			STEP_CODE:   byte_d = cmd_q.code;
			STEP_P1:     byte_d = cmd_q.param1;
			STEP_P2_HI:  byte_d = cmd_q.param2[PARAM2_W-1:BYTE_W];
			STEP_P2_LO:  byte_d = cmd_q.param2[BYTE_W-1:0];
			STEP_DATA:   byte_d = cmd_q.data;
			STEP_CRC_LO: begin
				byte_d = crc_q[BYTE_W-1:0];
				feed_d = 1'b0;
			end
			STEP_CRC_HI: begin
				byte_d = crc_q[CRC_W-1:BYTE_W];
				end_d  = 1'b1;
				feed_d = 1'b0;
			end
			default:     feed_d = 1'b0;
		endcase
	end

	// Command holding register and output payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
		end
		if (advance) begin
			out_byte_q <= byte_d;
			out_end_q  <= end_d;
		end
	end

	// Sequencer control, running CRC and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= STEP_COUNT;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= (cmd.kind == KIND_HEADER) ? STEP_COUNT : STEP_DATA;
			end else if (advance && done) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				step_q <= step_nxt;
			end
			if (advance && feed_d) begin
				crc_q <= crc_feed(crc_base, byte_d);
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (frame.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/command_frame_builder_crc16_top.sv -----
// ----------------------------------------------------------------------------
// Command frame builder with CRC-16 top level
// Turns header and data requests into framed byte streams with a CRC-16.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  req      in         operation, command_code, first_param, second_param,
//                      payload_length, payload_byte
//  frame    out        frame_byte, frame_end
//
// The front end accepts one request per cycle while the four-entry command
// queue has room. The back end sequencer sends one byte per cycle while the
// frame channel takes them: a data request sends one byte, or three when it
// closes the frame; a header sends five bytes, or seven with an empty payload.
// An idle sequencer first loads a command into its holding register before
// it sends the first byte. A byte waits in the output register until the
// frame channel takes it, and the sequencer holds meanwhile. Reset clears the
// queue, the frame tracking, the sequencer and the CRC; no clearing pass
// follows. A stall on the frame channel fills the queue and then drops req.ready.
// ----------------------------------------------------------------------------
`include "command_frame_builder_crc16_top_defines.svh"

module command_frame_builder_crc16_top
	import cfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cfb_req_if.sink     req,
	cfb_frame_if.source frame
);

	logic          push_valid;
	logic          push_ready;
	cmd_t          push_cmd;
	logic          pop_valid;
	logic          pop_ready;
	cmd_t          pop_cmd;
	front_status_t front_status;
	back_status_t  back_status;

	// Request classification.
	cfb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (push_valid),
		.cmd_ready (push_ready),
		.cmd       (push_cmd),
		.status    (front_status)
	);

	// Queue between the front and the back.
	cfb_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// Byte sequencer and CRC.
	cfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.frame     (frame),
		.status    (back_status)
	);

	// Every header request is offered to the queue as a command.
	`CFB_ASSERT_SAME(a_header_queued, clk, arst_n, req.valid && (req.operation == OP_HEADER), push_valid)
	// A data request with no open frame is never queued.
	`CFB_ASSERT_SAME(a_orphan_dropped, clk, arst_n, req.valid && (req.operation == OP_DATA) && !front_status.frame_open, !push_valid)
	// A command taken from the queue keeps the sequencer busy next cycle.
	`CFB_ASSERT_NEXT(a_pop_busy, clk, arst_n, pop_valid && pop_ready, back_status.busy)

endmodule
